// ===== design/frame_tick_accumulator_assert.svh =====
// Assertion macros for the frame tick accumulator.
// Included by frame_tick_accumulator, which checks its own control logic.
`ifndef FRAME_TICK_ACCUMULATOR_ASSERT_SVH
`define FRAME_TICK_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== design/fta_pkg.sv =====
// Package for the frame tick accumulator: widths, codes, step counts and state type.
// Has no dependencies; imported by frame_tick_accumulator.
package fta_pkg;

	localparam int FRAME_W    = 32;
	localparam int TICK_W     = 24;
	localparam int LIMIT_W    = 32;
	localparam int FRAC_W     = 17;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DVD_W      = 33;
	localparam int DVSR_W     = 57;
	localparam int PREM_W     = 58;
	localparam int CNT_W      = 6;

	localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 2'd1;

	localparam logic [TICK_W-1:0]  PERIOD_RESET = 24'd16666;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 32'd1000000;

	localparam logic [CNT_W-1:0] ADV_STEPS  = 6'd33;
	localparam logic [CNT_W-1:0] MUL_STEPS  = 6'd24;
	localparam logic [CNT_W-1:0] FRAC_STEPS = 6'd16;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADJ,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== design/frame_tick_accumulator.sv =====
// Frame tick accumulator: frame counter advanced by tick deltas, with progress queries.
// Depends on fta_pkg and on the macros in frame_tick_accumulator_assert.svh.
//
// Usage: one word enters on the s_axis channel (kind in tuser, operands in tdata) and
// leaves exactly one word on the m_axis channel with the frame count and tick remainder
// after the item, the ignored flag in tuser and the progress fraction (zero unless the
// item is a query). Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, since the block itself does not enforce this.
// The block works on one word at a time with a shared bit-serial restoring divider,
// one quotient bit per cycle, and a shift-add multiplier, one period bit per cycle.
// An advance runs 33 divider steps after acceptance; a query inside its interval runs
// 24 multiply steps, then an adjust and a compare, then 16 divider steps, or skips the
// divider when it clamps to complete; loads, ignored advances and queries outside their
// interval go straight to the done state.
// The next word is accepted the cycle after a result is moved to the output register,
// even when that result is still waiting for m_axis_tready.
// If the receiver stalls while a result is waiting, a finished item holds in its
// last state until the output register frees up.
// Reset clears the frame count and remainder, sets frame_period to 16666 and
// jump_limit to 1000000, and empties the output register.
module frame_tick_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// delta_ticks, new_frame, interval_start, interval_end
	input  logic [fta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [fta_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// frame_count, remainder_ticks, progress_fraction, zero fill
	output logic [fta_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// ignored
	output logic                           m_axis_tuser,
	input  logic                           cfg_we,
	input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fta_pkg::*;

	`include "frame_tick_accumulator_assert.svh"

	state_t               state_q, state_d;
	logic [TICK_W-1:0]    period_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [TICK_W-1:0]    tick_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 ign_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TICK_W-1:0]    mcand_q;
	logic [DVD_W-1:0]     span_q;
	logic [FRAME_W-1:0]   diff_q;
	logic [DVSR_W-1:0]    dvsr_q;
	logic [PREM_W-1:0]    prem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVD_W-1:0]     quo_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                 out_ign_q;

	logic [FRAME_W-1:0]   in_delta, in_new, in_start, in_end;
	logic [TICK_W-1:0]    p_eff;
	logic                 in_acc, out_load;
	logic [PREM_W-1:0]    div_t, div_sub;
	logic                 div_ge;
	logic [DVD_W-1:0]     quo_next;
	logic [FRAME_W-1:0]   frame_next;
	logic [TICK_W-1:0]    tick_next;

	assign in_delta = s_axis_tdata[31:0];
	assign in_new   = s_axis_tdata[63:32];
	assign in_start = s_axis_tdata[95:64];
	assign in_end   = s_axis_tdata[127:96];

	assign p_eff         = (period_q == '0) ? TICK_W'(1) : period_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign div_t    = {prem_q[PREM_W-2:0], dvd_q[DVD_W-1]};
	assign div_sub  = div_t - {1'b0, dvsr_q};
	assign div_ge   = (div_t >= {1'b0, dvsr_q});
	assign quo_next = {quo_q[DVD_W-2:0], div_ge};

	always_comb begin
		frame_next = frame_q;
		tick_next  = tick_q;
		case (kind_q)
			KIND_ADVANCE: begin
				if (!ign_q) begin
					frame_next = frame_q + quo_q[FRAME_W-1:0];
					tick_next  = prem_q[TICK_W-1:0];
				end
			end
			KIND_LOAD: begin
				frame_next = dvd_q[FRAME_W-1:0];
				tick_next  = '0;
			end
			default: begin
				frame_next = frame_q;
				tick_next  = tick_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DONE;
					case (s_axis_tuser)
						KIND_ADVANCE: begin
							if (in_delta <= limit_q) begin
								state_d = ST_DIV;
							end
						end
						KIND_QUERY: begin
							if (frame_q >= in_start && in_end >= frame_q) begin
								state_d = ST_MUL;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_ADJ;
				end
			end
			ST_ADJ: state_d = ST_CMP;
			ST_CMP: begin
				state_d = (prem_q >= {1'b0, dvsr_q}) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			limit_q     <= LIMIT_RESET;
			frame_q     <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_PERIOD: period_q <= cfg_data[TICK_W-1:0];
					REG_JUMP_LIMIT:   limit_q  <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				frame_q     <= frame_next;
				tick_q      <= tick_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tuser == KIND_ADVANCE) begin
						cnt_q <= ADV_STEPS;
					end else begin
						cnt_q <= MUL_STEPS;
					end
				end
				ST_MUL, ST_DIV: cnt_q <= cnt_q - CNT_W'(1);
				ST_CMP: cnt_q <= FRAC_STEPS;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					kind_q <= s_axis_tuser;
					ign_q  <= (s_axis_tuser == KIND_ADVANCE) && (in_delta > limit_q);
					frac_q <= (s_axis_tuser == KIND_QUERY && frame_q >= in_start
						&& in_end < frame_q) ? FRAC_ONE : '0;
					case (s_axis_tuser)
						KIND_ADVANCE: begin
							dvd_q  <= {1'b0, in_delta} + {9'b0, tick_q};
							prem_q <= '0;
							dvsr_q <= {(DVSR_W-TICK_W)'(0), p_eff};
							quo_q  <= '0;
						end
						KIND_LOAD: begin
							dvd_q <= {1'b0, in_new};
						end
						KIND_QUERY: begin
							span_q  <= {1'b0, in_end} - {1'b0, in_start} + DVD_W'(1);
							diff_q  <= frame_q - in_start;
							mcand_q <= p_eff;
							dvsr_q  <= '0;
							prem_q  <= '0;
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				dvsr_q  <= {dvsr_q[DVSR_W-2:0], 1'b0}
					+ (mcand_q[TICK_W-1] ? {(DVSR_W-DVD_W)'(0), span_q} : '0);
				prem_q  <= {prem_q[PREM_W-2:0], 1'b0}
					+ (mcand_q[TICK_W-1] ? {(PREM_W-FRAME_W)'(0), diff_q} : '0);
				mcand_q <= {mcand_q[TICK_W-2:0], 1'b0};
			end
			ST_ADJ: begin
				prem_q <= prem_q + {(PREM_W-TICK_W)'(0), tick_q};
			end
			ST_CMP: begin
				if (prem_q >= {1'b0, dvsr_q}) begin
					frac_q <= FRAC_ONE;
				end
				dvd_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				prem_q <= div_ge ? div_sub : div_t;
				quo_q  <= quo_next;
				dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
				if (cnt_q == CNT_W'(1) && kind_q == KIND_QUERY) begin
					frac_q <= {1'b0, quo_next[FRAC_W-2:0]};
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {(OUT_DATA_W-FRAC_W-TICK_W-FRAME_W)'(0), frac_q, tick_next,
				frame_next};
			out_ign_q  <= ign_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ign_q;

	`ASSERT_IMPLIES(a_div_rem_below_divisor, clk, arst_n, state_q == ST_DIV,
		prem_q < {1'b0, dvsr_q})
	`ASSERT_IMPLIES(a_div_divisor_nonzero, clk, arst_n, state_q == ST_DIV,
		dvsr_q != '0)
	`ASSERT_IMPLIES(a_iter_count_live, clk, arst_n,
		state_q == ST_DIV || state_q == ST_MUL, cnt_q != '0)
	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, state_q != ST_IDLE)

endmodule
